/* design/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and the reciprocal table of the PLL settings checker.
// ----------------------------------------------------------------------------
`default_nettype none
package psc_pkg;

  localparam int unsigned OscW   = 27;
  localparam int unsigned RecipW = 32;
  localparam int unsigned PerW   = 21;   // osc / M once it passed its range check
  localparam int unsigned VcoW   = 30;   // per * N before the VCO range check

  localparam logic [OscW-1:0] INT_OSC_RESET = 27'd16000000;
  localparam logic [OscW-1:0] EXT_OSC_RESET = 27'd25000000;

  localparam logic [OscW-1:0] PER_MIN  = 27'd1000000;
  localparam logic [OscW-1:0] PER_MAX  = 27'd2000000;
  localparam logic [VcoW-1:0] VCO_MIN  = 30'd192000000;
  localparam logic [VcoW-1:0] VCO_MAX  = 30'd432000000;
  localparam logic [VcoW-1:0] PLL_MAX  = 30'd84000000;
  localparam logic [VcoW-1:0] USB_MAX  = 30'd48000000;
  localparam logic [8:0]      N_MIN    = 9'd192;
  localparam logic [8:0]      N_MAX    = 9'd432;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_RUNNING  = 4'd1,
    ST_SOURCE   = 4'd2,
    ST_M        = 4'd3,
    ST_N        = 4'd4,
    ST_P        = 4'd5,
    ST_Q        = 4'd6,
    ST_VCO      = 4'd7,
    ST_PLL      = 4'd8,
    ST_USB      = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    SRC_INT = 2'd0,
    SRC_EXT = 2'd1
  } src_t;

  typedef enum logic {
    REG_INT_OSC = 1'b0,
    REG_EXT_OSC = 1'b1
  } reg_idx_t;

  // floor(2^32 / d); entries for zero and one are never used.
  localparam logic [RecipW-1:0] RECIP [64] = '{
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'd2147483648, 32'd1431655765,
    32'd1073741824, 32'd858993459, 32'd715827882, 32'd613566756,
    32'd536870912, 32'd477218588, 32'd429496729, 32'd390451572,
    32'd357913941, 32'd330382099, 32'd306783378, 32'd286331153,
    32'd268435456, 32'd252645135, 32'd238609294, 32'd226050910,
    32'd214748364, 32'd204522252, 32'd195225786, 32'd186737708,
    32'd178956970, 32'd171798691, 32'd165191049, 32'd159072862,
    32'd153391689, 32'd148102320, 32'd143165576, 32'd138547332,
    32'd134217728, 32'd130150524, 32'd126322567, 32'd122713351,
    32'd119304647, 32'd116080197, 32'd113025455, 32'd110127366,
    32'd107374182, 32'd104755299, 32'd102261126, 32'd99882960,
    32'd97612893, 32'd95443717, 32'd93368854, 32'd91382282,
    32'd89478485, 32'd87652393, 32'd85899345, 32'd84215045,
    32'd82595524, 32'd81037118, 32'd79536431, 32'd78090314,
    32'd76695844, 32'd75350303, 32'd74051160, 32'd72796055,
    32'd71582788, 32'd70409299, 32'd69273666, 32'd68174084
  };

endpackage
`default_nettype wire

/* design/psc_div_m.sv */
// ----------------------------------------------------------------------------
// psc_div_m
// Two-stage divide of the oscillator frequency by M: reciprocal multiply,
// then a remainder check that adds the missing one.
// ----------------------------------------------------------------------------
`default_nettype none
module psc_div_m (
  input  wire logic                        clk,
  input  wire logic                        adv_a,
  input  wire logic                        adv_b,
  input  wire logic [psc_pkg::OscW-1:0]    osc,
  input  wire logic [5:0]                  m,
  output logic      [psc_pkg::OscW-1:0]    per
);

  logic [psc_pkg::OscW-1:0]   osc_a_r;
  logic [5:0]                 m_a_r;
  logic [psc_pkg::OscW-1:0]   quo_a_r;
  logic [psc_pkg::OscW+psc_pkg::RecipW-1:0] prod_a;
  logic [psc_pkg::OscW+5:0]   qm_b;
  logic [psc_pkg::OscW+5:0]   rem_b;
  logic [psc_pkg::OscW-1:0]   per_r;
  logic [psc_pkg::OscW-1:0]   per_nxt;

  assign prod_a = {{psc_pkg::RecipW{1'b0}}, osc}
                * {{psc_pkg::OscW{1'b0}}, psc_pkg::RECIP[m]};

  always_ff @(posedge clk) begin
    if (adv_a) begin
      osc_a_r <= osc;
      m_a_r   <= m;
      quo_a_r <= prod_a[psc_pkg::OscW+psc_pkg::RecipW-1:psc_pkg::RecipW];
    end
  end

  // estimate is low by at most one
  always_comb begin
    qm_b    = {6'd0, quo_a_r} * {{psc_pkg::OscW{1'b0}}, m_a_r};
    rem_b   = {6'd0, osc_a_r} - qm_b;
    per_nxt = quo_a_r;
    if (rem_b >= {{psc_pkg::OscW{1'b0}}, m_a_r}) begin
      per_nxt = quo_a_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      per_r <= per_nxt;
    end
  end

  assign per = per_r;

endmodule
`default_nettype wire

/* design/psc_out_div.sv */
// ----------------------------------------------------------------------------
// psc_out_div
// Divides the VCO by the P and Q dividers in two stages and applies the
// VCO, PLL and USB limit checks.
// ----------------------------------------------------------------------------
`default_nettype none
module psc_out_div (
  input  wire logic                       clk,
  input  wire logic                       adv_a,
  input  wire logic                       adv_b,
  input  wire psc_pkg::status_t           status_in,
  input  wire logic [psc_pkg::VcoW-1:0]   vco,
  input  wire logic [1:0]                 p_code,
  input  wire logic [3:0]                 q_div,
  output psc_pkg::status_t                status,
  output logic [28:0]                     vco_hz,
  output logic [27:0]                     pll_hz,
  output logic [27:0]                     usb_hz
);

  localparam int unsigned PW = psc_pkg::VcoW + psc_pkg::RecipW;

  psc_pkg::status_t          st_a_r;
  logic [psc_pkg::VcoW-1:0]  vco_a_r;
  logic [psc_pkg::VcoW-1:0]  qp_a_r;
  logic [psc_pkg::VcoW-1:0]  qu_a_r;
  logic [3:0]                dp_a_r;
  logic [3:0]                dq_a_r;
  logic [3:0]                dp;
  logic [PW-1:0]             prod_p;
  logic [PW-1:0]             prod_u;
  psc_pkg::status_t          st_a_nxt;

  psc_pkg::status_t          status_r, status_nxt;
  logic [28:0]               vco_r, vco_nxt;
  logic [27:0]               pll_r, pll_nxt;
  logic [27:0]               usb_r, usb_nxt;
  logic [psc_pkg::VcoW+3:0]  rp, ru;
  logic [psc_pkg::VcoW-1:0]  pll_b, usb_b;

  assign dp = {1'b0, p_code, 1'b0} + 4'd2;

  always_comb begin
    prod_p = {{psc_pkg::RecipW{1'b0}}, vco}
           * {{psc_pkg::VcoW{1'b0}}, psc_pkg::RECIP[{2'b00, dp}]};
    prod_u = {{psc_pkg::RecipW{1'b0}}, vco}
           * {{psc_pkg::VcoW{1'b0}}, psc_pkg::RECIP[{2'b00, q_div}]};
    st_a_nxt = status_in;
    if (status_in == psc_pkg::ST_OK &&
        (vco < psc_pkg::VCO_MIN || vco > psc_pkg::VCO_MAX)) begin
      st_a_nxt = psc_pkg::ST_VCO;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      st_a_r  <= st_a_nxt;
      vco_a_r <= vco;
      qp_a_r  <= prod_p[PW-1:psc_pkg::RecipW];
      qu_a_r  <= prod_u[PW-1:psc_pkg::RecipW];
      dp_a_r  <= dp;
      dq_a_r  <= q_div;
    end
  end

  always_comb begin
    rp = {4'd0, vco_a_r} - {4'd0, qp_a_r} * {{psc_pkg::VcoW{1'b0}}, dp_a_r};
    ru = {4'd0, vco_a_r} - {4'd0, qu_a_r} * {{psc_pkg::VcoW{1'b0}}, dq_a_r};
    pll_b = qp_a_r;
    usb_b = qu_a_r;
    if (rp >= {{psc_pkg::VcoW{1'b0}}, dp_a_r}) begin
      pll_b = qp_a_r + 1'b1;
    end
    if (ru >= {{psc_pkg::VcoW{1'b0}}, dq_a_r}) begin
      usb_b = qu_a_r + 1'b1;
    end
    status_nxt = st_a_r;
    if (st_a_r == psc_pkg::ST_OK) begin
      if (pll_b > psc_pkg::PLL_MAX) begin
        status_nxt = psc_pkg::ST_PLL;
      end else if (usb_b > psc_pkg::USB_MAX) begin
        status_nxt = psc_pkg::ST_USB;
      end
    end
    vco_nxt = vco_a_r[28:0];
    pll_nxt = pll_b[27:0];
    usb_nxt = usb_b[27:0];
    // zero every frequency on any error
    if (status_nxt != psc_pkg::ST_OK) begin
      vco_nxt = '0;
      pll_nxt = '0;
      usb_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      status_r <= status_nxt;
      vco_r    <= vco_nxt;
      pll_r    <= pll_nxt;
      usb_r    <= usb_nxt;
    end
  end

  assign status = status_r;
  assign vco_hz = vco_r;
  assign pll_hz = pll_r;
  assign usb_hz = usb_r;

endmodule
`default_nettype wire

/* design/pll_settings_checker.sv */
// ----------------------------------------------------------------------------
// pll_settings_checker
// Checks a proposed PLL setting and reports the resulting clock frequencies.
// ----------------------------------------------------------------------------
// Six-stage pipeline, one setting per cycle when the result side does not stall.
// Field checks and oscillator select, the two-stage reciprocal divide
// by M, the VCO multiply, and the two-stage divide by P and Q set the stages.
// Each stage moves on when it is empty or the one after it moves, so a stall
// on the result side fills the bubbles before it backs up to in_stall.
// Oscillator registers sit at 0x0 (internal) and 0x4 (external).
`default_nettype none
module pll_settings_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_pll_active,
  input  wire logic [1:0]  in_source_sel,
  input  wire logic [5:0]  in_m_divider,
  input  wire logic [8:0]  in_n_multiplier,
  input  wire logic [1:0]  in_p_code,
  input  wire logic [3:0]  in_q_divider,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_status,
  output logic [28:0]      out_vco_hz,
  output logic [27:0]      out_pll_hz,
  output logic [27:0]      out_usb_hz
);

  logic [psc_pkg::OscW-1:0] int_osc_r, ext_osc_r;
  logic [5:0] v_r;
  logic [5:0] adv;

  psc_pkg::status_t         st1_r, st1_nxt, st3_r, st4_r, st4_nxt;
  logic [psc_pkg::OscW-1:0] osc1_r;
  logic [5:0]               m1_r;
  logic [8:0]               n1_r, n2_r, n3_r;
  logic [1:0]               p1_r, p2_r, p3_r, p4_r;
  logic [3:0]               q1_r, q2_r, q3_r, q4_r;
  psc_pkg::status_t         st2_r;
  logic [psc_pkg::OscW-1:0] per3;
  logic [psc_pkg::VcoW-1:0] vco4_r;
  psc_pkg::status_t         st_out;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_osc_r <= psc_pkg::INT_OSC_RESET;
      ext_osc_r <= psc_pkg::EXT_OSC_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (psc_pkg::reg_idx_t'(paddr[2]))
        psc_pkg::REG_INT_OSC: int_osc_r <= pwdata[psc_pkg::OscW-1:0];
        psc_pkg::REG_EXT_OSC: ext_osc_r <= pwdata[psc_pkg::OscW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (psc_pkg::reg_idx_t'(paddr[2]))
      psc_pkg::REG_INT_OSC: prdata = {5'd0, int_osc_r};
      psc_pkg::REG_EXT_OSC: prdata = {5'd0, ext_osc_r};
      default: prdata = '0;
    endcase
  end

  // stage advance, back to front
  always_comb begin
    adv[5] = !v_r[5] || !out_stall;
    for (int i = 4; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end
  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int i = 1; i < 6; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // field checks in priority order
  always_comb begin
    st1_nxt = psc_pkg::ST_OK;
    if (in_pll_active) begin
      st1_nxt = psc_pkg::ST_RUNNING;
    end else if (in_source_sel > psc_pkg::SRC_EXT) begin
      st1_nxt = psc_pkg::ST_SOURCE;
    end else if (in_m_divider < 6'd2) begin
      st1_nxt = psc_pkg::ST_M;
    end else if (in_n_multiplier < psc_pkg::N_MIN || in_n_multiplier > psc_pkg::N_MAX) begin
      st1_nxt = psc_pkg::ST_N;
    end else if (in_q_divider < 4'd2) begin
      st1_nxt = psc_pkg::ST_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st1_r  <= st1_nxt;
      osc1_r <= (in_source_sel == psc_pkg::SRC_INT) ? int_osc_r : ext_osc_r;
      m1_r   <= in_m_divider;
      n1_r   <= in_n_multiplier;
      p1_r   <= in_p_code;
      q1_r   <= in_q_divider;
    end
    if (adv[1]) begin
      st2_r <= st1_r;
      n2_r  <= n1_r;
      p2_r  <= p1_r;
      q2_r  <= q1_r;
    end
    if (adv[2]) begin
      st3_r <= st2_r;
      n3_r  <= n2_r;
      p3_r  <= p2_r;
      q3_r  <= q2_r;
    end
    if (adv[3]) begin
      st4_r  <= st4_nxt;
      vco4_r <= {{(psc_pkg::VcoW-psc_pkg::PerW){1'b0}}, per3[psc_pkg::PerW-1:0]}
              * {{(psc_pkg::VcoW-9){1'b0}}, n3_r};
      p4_r   <= p3_r;
      q4_r   <= q3_r;
    end
  end

  psc_div_m u_div_m (
    .clk   (clk),
    .adv_a (adv[1]),
    .adv_b (adv[2]),
    .osc   (osc1_r),
    .m     (m1_r),
    .per   (per3)
  );

  always_comb begin
    st4_nxt = st3_r;
    if (st3_r == psc_pkg::ST_OK && (per3 < psc_pkg::PER_MIN || per3 > psc_pkg::PER_MAX)) begin
      st4_nxt = psc_pkg::ST_VCO;
    end
  end

  psc_out_div u_out_div (
    .clk       (clk),
    .adv_a     (adv[4]),
    .adv_b     (adv[5]),
    .status_in (st4_r),
    .vco       (vco4_r),
    .p_code    (p4_r),
    .q_div     (q4_r),
    .status    (st_out),
    .vco_hz    (out_vco_hz),
    .pll_hz    (out_pll_hz),
    .usb_hz    (out_usb_hz)
  );

  assign out_status = st_out;
  assign out_valid  = v_r[5];

endmodule
`default_nettype wire

/* verif/pll_settings_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_settings_scoreboard
// Watches the setting and result channels of the PLL settings checker and the
// oscillator register writes, computes the expected status and frequencies
// of every accepted setting and compares them in order with the results.
// ----------------------------------------------------------------------------
module pll_settings_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_pll_active,
  input  wire logic [1:0]  in_source_sel,
  input  wire logic [5:0]  in_m_divider,
  input  wire logic [8:0]  in_n_multiplier,
  input  wire logic [1:0]  in_p_code,
  input  wire logic [3:0]  in_q_divider,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_status,
  input  wire logic [28:0] out_vco_hz,
  input  wire logic [27:0] out_pll_hz,
  input  wire logic [27:0] out_usb_hz,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    psc_pkg::status_t status;
    logic [28:0]      vco_hz;
    logic [27:0]      pll_hz;
    logic [27:0]      usb_hz;
  } clocks_t;

  logic [psc_pkg::OscW-1:0] int_osc;
  logic [psc_pkg::OscW-1:0] ext_osc;
  clocks_t                  clocks_q[$];

  function automatic clocks_t predict_clocks(logic active, logic [1:0] src,
                                             logic [5:0] m, logic [8:0] n,
                                             logic [1:0] p, logic [3:0] q);
    clocks_t    r;
    logic [63:0] osc;
    logic [63:0] per;
    logic [63:0] vco;
    logic [63:0] pll;
    logic [63:0] usb;
    r = '0;
    r.status = psc_pkg::ST_OK;
    vco = 64'd0;
    pll = 64'd0;
    usb = 64'd0;
    if (active) r.status = psc_pkg::ST_RUNNING;
    else if (src != psc_pkg::SRC_INT && src != psc_pkg::SRC_EXT) r.status = psc_pkg::ST_SOURCE;
    else if (m < 2) r.status = psc_pkg::ST_M;
    else if (n < 192 || n > 432) r.status = psc_pkg::ST_N;
    else if (q < 2) r.status = psc_pkg::ST_Q;
    else begin
      osc = (src == psc_pkg::SRC_INT) ? 64'(int_osc) : 64'(ext_osc);
      per = osc / m;
      if (per < 64'd1000000 || per > 64'd2000000) r.status = psc_pkg::ST_VCO;
      else begin
        vco = per * n;
        if (vco < 64'd192000000 || vco > 64'd432000000) r.status = psc_pkg::ST_VCO;
        else begin
          pll = vco / ((64'(p) + 64'd1) * 64'd2);
          usb = vco / q;
          if (pll > 64'd84000000) r.status = psc_pkg::ST_PLL;
          else if (usb > 64'd48000000) r.status = psc_pkg::ST_USB;
        end
      end
    end
    if (r.status == psc_pkg::ST_OK) begin
      r.vco_hz = vco[28:0];
      r.pll_hz = pll[27:0];
      r.usb_hz = usb[27:0];
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: %s got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    clocks_t want;
    if (!rst_n) begin
      int_osc <= psc_pkg::INT_OSC_RESET;
      ext_osc <= psc_pkg::EXT_OSC_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == psc_pkg::REG_EXT_OSC) ext_osc <= pwdata[psc_pkg::OscW-1:0];
        else int_osc <= pwdata[psc_pkg::OscW-1:0];
      end
      if (in_valid && !in_stall)
        clocks_q.push_back(predict_clocks(in_pll_active, in_source_sel, in_m_divider,
                                          in_n_multiplier, in_p_code, in_q_divider));
      if (out_valid && !out_stall) begin
        if (clocks_q.size() == 0)
          report("unexpected result, status", longint'(out_status), 64'sd0);
        else begin
          want = clocks_q.pop_front();
          if (out_status != want.status)
            report("status", longint'(out_status), longint'(want.status));
          if (out_vco_hz != want.vco_hz)
            report("vco_hz", longint'(out_vco_hz), longint'(want.vco_hz));
          if (out_pll_hz != want.pll_hz)
            report("pll_hz", longint'(out_pll_hz), longint'(want.pll_hz));
          if (out_usb_hz != want.usb_hz)
            report("usb_hz", longint'(out_usb_hz), longint'(want.usb_hz));
        end
      end
      pending <= clocks_q.size();
    end
  end

endmodule

/* verif/pll_settings_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_settings_checker_tb
// Drives directed and random PLL settings under several oscillator register
// settings, with random gaps and stalls on both channels, and reports the
// verdict of the scoreboard.
// ----------------------------------------------------------------------------
module pll_settings_checker_tb;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        in_pll_active;
  logic [1:0]  in_source_sel;
  logic [5:0]  in_m_divider;
  logic [8:0]  in_n_multiplier;
  logic [1:0]  in_p_code;
  logic [3:0]  in_q_divider;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_status;
  logic [28:0] out_vco_hz;
  logic [27:0] out_pll_hz;
  logic [27:0] out_usb_hz;
  int          mismatches;
  int          pending;
  bit          calm;
  bit          hold_go;
  logic [psc_pkg::OscW-1:0] int_osc;
  logic [psc_pkg::OscW-1:0] ext_osc;

  pll_settings_checker i_dut (.*);

  pll_settings_scoreboard i_scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (199) @(negedge clk);
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
      end
    end
  end

  task automatic send(logic active, logic [1:0] src, logic [5:0] m, logic [8:0] n,
                      logic [1:0] p, logic [3:0] q);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_pll_active   <= active;
    in_source_sel   <= src;
    in_m_divider    <= m;
    in_n_multiplier <= n;
    in_p_code       <= p;
    in_q_divider    <= q;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(psc_pkg::reg_idx_t idx, logic [psc_pkg::OscW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_oscs(logic [psc_pkg::OscW-1:0] i_hz, logic [psc_pkg::OscW-1:0] e_hz);
    write_reg(psc_pkg::REG_INT_OSC, i_hz);
    write_reg(psc_pkg::REG_EXT_OSC, e_hz);
    int_osc = i_hz;
    ext_osc = e_hz;
  endtask

  // mostly settings that reach the frequency checks, the rest noise
  task automatic random_items(int count);
    logic [1:0]               src;
    logic [psc_pkg::OscW-1:0] osc;
    int unsigned              m;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3 && i < count / 3 + 60);
      if (i == count / 2) hold_go = 1'b1;
      if ($urandom_range(99) < 70) begin
        src = 2'($urandom_range(1));
        osc = (src == psc_pkg::SRC_INT) ? int_osc : ext_osc;
        m = osc / $urandom_range(2000000, 1000000);
        if (m < 2) m = $urandom_range(5, 2);
        if (m > 63) m = $urandom_range(63, 58);
        send(1'b0, src, 6'(m), 9'($urandom_range(432, 192)), 2'($urandom_range(3)),
             4'($urandom_range(15, 2)));
      end else begin
        send(1'($urandom_range(1)), 2'($urandom_range(3)), 6'($urandom_range(63)),
             9'($urandom_range(511)), 2'($urandom_range(3)), 4'($urandom_range(15)));
      end
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_pll_active = 1'b0;
    in_source_sel = '0;
    in_m_divider = '0;
    in_n_multiplier = '0;
    in_p_code = '0;
    in_q_divider = '0;
    calm = 1'b0;
    hold_go = 1'b0;
    int_osc = psc_pkg::INT_OSC_RESET;
    ext_osc = psc_pkg::EXT_OSC_RESET;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset oscillators, 16 MHz internal gives 1 MHz at M = 16
    send(1'b1, psc_pkg::SRC_INT, 6'd16, 9'd336, 2'd1, 4'd7);
    send(1'b0, 2'd2, 6'd16, 9'd336, 2'd1, 4'd7);
    send(1'b0, 2'd3, 6'd16, 9'd336, 2'd1, 4'd7);
    send(1'b0, psc_pkg::SRC_INT, 6'd0, 9'd336, 2'd1, 4'd7);
    send(1'b0, psc_pkg::SRC_INT, 6'd1, 9'd336, 2'd1, 4'd7);
    send(1'b0, psc_pkg::SRC_INT, 6'd63, 9'd336, 2'd1, 4'd7);
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd0, 2'd1, 4'd7);
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd191, 2'd1, 4'd7);
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd433, 2'd1, 4'd7);
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd511, 2'd1, 4'd7);
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd336, 2'd1, 4'd0);
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd336, 2'd1, 4'd1);
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd336, 2'd1, 4'd15);
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd336, 2'd1, 4'd7);   // exactly at the PLL and USB limits
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd336, 2'd0, 4'd7);   // PLL clock too fast
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd336, 2'd1, 4'd6);   // USB clock too fast
    send(1'b0, psc_pkg::SRC_INT, 6'd16, 9'd192, 2'd2, 4'd4);
    send(1'b0, psc_pkg::SRC_INT, 6'd8, 9'd216, 2'd3, 4'd9);    // VCO at its upper edge
    send(1'b0, psc_pkg::SRC_EXT, 6'd25, 9'd432, 2'd3, 4'd9);
    send(1'b0, psc_pkg::SRC_EXT, 6'd12, 9'd200, 2'd3, 4'd9);   // osc/M above 2 MHz
    send(1'b0, psc_pkg::SRC_EXT, 6'd26, 9'd300, 2'd3, 4'd9);   // osc/M below 1 MHz
    drain();
    random_items(300);

    set_oscs(27'd16000000, 27'd25000000);
    random_items(250);

    // random settings under extreme oscillator values, each batch drained before the next
    set_oscs(27'd1, 27'd100000000);
    random_items(250);
    set_oscs(27'd0, 27'h7FFFFFF);
    random_items(250);
    set_oscs(27'd100000000, 27'd1);
    random_items(250);
    set_oscs(27'd8000000, 27'd12000000);
    random_items(250);

    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
design/psc_pkg.sv
design/psc_div_m.sv
design/psc_out_div.sv
design/pll_settings_checker.sv
verif/pll_settings_scoreboard.sv
verif/pll_settings_checker_tb.sv
